>>> rtl/tmtw_pkg.sv
// Shared types and constants of the text-mode terminal writer.
package tmtw_pkg;

  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 25;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned CUR_COL_W = 7;
  localparam int unsigned CUR_ROW_W = 5;

  localparam logic [BYTE_W-1:0] CH_NEWLINE  = 8'd10;
  localparam logic [BYTE_W-1:0] CH_RETURN   = 8'd13;
  localparam logic [BYTE_W-1:0] CH_SPACE    = 8'd32;
  localparam logic [BYTE_W-1:0] RESET_COLOR = 8'h0F;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_WRITE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_FILL,
    ST_RESP
  } state_e;

endpackage

>>> rtl/tmtw_if.sv
// Channel interfaces of the text-mode terminal writer: command, response and colour write.
interface tmtw_cmd_if;
  import tmtw_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [BYTE_W-1:0] char_code;
  logic [BYTE_W-1:0] cell_color;
  logic [BYTE_W-1:0] col_in;
  logic [BYTE_W-1:0] row_in;
  modport source (output valid, op, char_code, cell_color, col_in, row_in, input ready);
  modport sink   (input valid, op, char_code, cell_color, col_in, row_in, output ready);
endinterface

interface tmtw_rsp_if;
  import tmtw_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [WORD_W-1:0]    cell_word;
  logic [CUR_COL_W-1:0] cursor_col;
  logic [CUR_ROW_W-1:0] cursor_row;
  logic                 scrolled;
  modport source (output valid, cell_word, cursor_col, cursor_row, scrolled, input ready);
  modport sink   (input valid, cell_word, cursor_col, cursor_row, scrolled, output ready);
endinterface

interface tmtw_cfg_if;
  import tmtw_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_color;
  modport source (output valid, text_color, input ready);
  modport sink   (input valid, text_color, output ready);
endinterface

>>> rtl/tmtw_screen_ram.sv
// Screen store: one write port and one registered read port.
module tmtw_screen_ram #(
  parameter int unsigned DEPTH  = 2000,
  parameter int unsigned ADDR_W = 11
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [ADDR_W-1:0]           waddr_i,
  input  logic [tmtw_pkg::WORD_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [ADDR_W-1:0]           raddr_i,
  output logic [tmtw_pkg::WORD_W-1:0] rdata_o
);
  import tmtw_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/tmtw_ctrl.sv
// Sequencer of the terminal writer: cursor, command execution, scroll and fill sweeps.
module tmtw_ctrl #(
  parameter int unsigned COLUMNS = tmtw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tmtw_pkg::ROWS_DEF,
  parameter int unsigned ADDR_W  = 11
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [tmtw_pkg::BYTE_W-1:0] text_color_i,
  tmtw_cmd_if.sink                    cmd_i,
  tmtw_rsp_if.source                  rsp_o,
  output logic                        ram_we_o,
  output logic [ADDR_W-1:0]           ram_waddr_o,
  output logic [tmtw_pkg::WORD_W-1:0] ram_wdata_o,
  output logic                        ram_re_o,
  output logic [ADDR_W-1:0]           ram_raddr_o,
  input  logic [tmtw_pkg::WORD_W-1:0] ram_rdata_i
);
  import tmtw_pkg::*;

  localparam int unsigned CELLS  = COLUMNS * ROWS;
  localparam int unsigned SHIFT_N = CELLS - COLUMNS;
  localparam int unsigned COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned CNT_W  = $clog2(CELLS + 1);

  localparam logic [WORD_W-1:0] RESET_BLANK = {RESET_COLOR, CH_SPACE};

  state_e             state_q, state_d;
  op_e                op_q, op_d;
  logic [BYTE_W-1:0]  char_q, char_d;
  logic [BYTE_W-1:0]  color_q, color_d;
  logic [BYTE_W-1:0]  col_in_q, col_in_d;
  logic [BYTE_W-1:0]  row_in_q, row_in_d;
  logic [COL_W-1:0]   cur_col_q, cur_col_d;
  logic [ROW_W-1:0]   cur_row_q, cur_row_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [WORD_W-1:0]  blank_q, blank_d;
  logic               scrolled_q, scrolled_d;

  logic                 rsp_valid_q, rsp_valid_d;
  logic [WORD_W-1:0]    rsp_word_q, rsp_word_d;
  logic [CUR_COL_W-1:0] rsp_col_q, rsp_col_d;
  logic [CUR_ROW_W-1:0] rsp_row_q, rsp_row_d;
  logic                 rsp_scr_q, rsp_scr_d;

  logic               in_range;
  logic [ADDR_W-1:0]  pos_addr;
  logic [ADDR_W-1:0]  cur_addr;
  logic               is_nl, is_cr, col_last, row_last, adv_row, need_scroll;

  assign in_range = ({1'b0, col_in_q} < 9'(COLUMNS)) && ({1'b0, row_in_q} < 9'(ROWS));
  assign pos_addr = ADDR_W'(ADDR_W'(row_in_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_in_q));
  assign cur_addr = ADDR_W'(ADDR_W'(cur_row_q) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col_q));

  assign is_nl       = (char_q == CH_NEWLINE);
  assign is_cr       = (char_q == CH_RETURN);
  assign col_last    = (cur_col_q == COL_W'(COLUMNS - 1));
  assign row_last    = (cur_row_q == ROW_W'(ROWS - 1));
  assign adv_row     = is_nl || (!is_cr && col_last);
  assign need_scroll = adv_row && row_last;

  assign cmd_i.ready      = (state_q == ST_IDLE);
  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.cell_word  = rsp_word_q;
  assign rsp_o.cursor_col = rsp_col_q;
  assign rsp_o.cursor_row = rsp_row_q;
  assign rsp_o.scrolled   = rsp_scr_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    char_d      = char_q;
    color_d     = color_q;
    col_in_d    = col_in_q;
    row_in_d    = row_in_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    cnt_d       = cnt_q;
    blank_d     = blank_q;
    scrolled_d  = scrolled_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_word_d  = rsp_word_q;
    rsp_col_d   = rsp_col_q;
    rsp_row_d   = rsp_row_q;
    rsp_scr_d   = rsp_scr_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = cur_addr;
    ram_wdata_o = {text_color_i, char_q};
    ram_re_o    = 1'b0;
    ram_raddr_o = pos_addr;

    unique case (state_q)
      ST_INIT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = cnt_q[ADDR_W-1:0];
        ram_wdata_o = RESET_BLANK;
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(CELLS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_i.valid) begin
          op_d     = op_e'(cmd_i.op);
          char_d   = cmd_i.char_code;
          color_d  = cmd_i.cell_color;
          col_in_d = cmd_i.col_in;
          row_in_d = cmd_i.row_in;
          state_d  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        scrolled_d = 1'b0;
        blank_d    = {text_color_i, CH_SPACE};
        cnt_d      = '0;
        state_d    = ST_RESP;
        unique case (op_q)
          OP_PUT: begin
            ram_we_o    = !is_nl && !is_cr;
            ram_waddr_o = cur_addr;
            ram_wdata_o = {text_color_i, char_q};
            if (is_nl || is_cr || col_last) begin
              cur_col_d = '0;
            end else begin
              cur_col_d = cur_col_q + 1'b1;
            end
            // hold the last row on scroll, the sweep moves the text instead
            if (adv_row && !row_last) begin
              cur_row_d = cur_row_q + 1'b1;
            end
            if (need_scroll) begin
              scrolled_d = 1'b1;
              state_d    = ST_SCROLL;
            end
          end
          OP_WRITE: begin
            ram_we_o    = in_range;
            ram_waddr_o = pos_addr;
            ram_wdata_o = {color_q, char_q};
          end
          OP_CLEAR: begin
            cur_col_d = '0;
            cur_row_d = '0;
            state_d   = ST_FILL;
          end
          OP_READ: begin
            ram_re_o    = 1'b1;
            ram_raddr_o = pos_addr;
          end
          default: ;
        endcase
      end
      ST_SCROLL: begin
        // read one row ahead, write back the cell read in the previous cycle
        ram_re_o    = (cnt_q < CNT_W'(SHIFT_N));
        ram_raddr_o = ADDR_W'(cnt_q + CNT_W'(COLUMNS));
        ram_we_o    = (cnt_q != '0);
        ram_waddr_o = ADDR_W'(cnt_q - 1'b1);
        ram_wdata_o = ram_rdata_i;
        if (cnt_q == CNT_W'(SHIFT_N)) begin
          state_d = ST_FILL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FILL: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = cnt_q[ADDR_W-1:0];
        ram_wdata_o = blank_q;
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(CELLS - 1)) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          rsp_word_d  = (op_q == OP_READ && in_range) ? ram_rdata_i : '0;
          rsp_col_d   = CUR_COL_W'(cur_col_q);
          rsp_row_d   = CUR_ROW_W'(cur_row_q);
          rsp_scr_d   = scrolled_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    char_q     <= char_d;
    color_q    <= color_d;
    col_in_q   <= col_in_d;
    row_in_q   <= row_in_d;
    blank_q    <= blank_d;
    scrolled_q <= scrolled_d;
    rsp_word_q <= rsp_word_d;
    rsp_col_q  <= rsp_col_d;
    rsp_row_q  <= rsp_row_d;
    rsp_scr_q  <= rsp_scr_d;
  end

endmodule

>>> rtl/text_mode_terminal_writer_core.sv
// Top level of the text-mode terminal writer: colour register, sequencer and screen store.
//
// Usage: commands arrive on cmd_i (valid/ready): put character at the cursor,
// write a cell at a position, clear the screen, or read a cell. Every command
// yields exactly one item on rsp_o carrying the cell read (in-range reads only, else 0),
// the cursor after the command and a flag telling whether the screen scrolled.
// cfg_i writes the attribute byte used for printed characters, scroll fill and
// clear; it is always ready. It is to be written while no command is in flight;
// the block itself does not enforce this. Timing: a command is taken in ST_IDLE,
// executed in ST_EXEC and its response is registered in ST_RESP; cmd_i is ready
// only in ST_IDLE, so no new command is taken before the last response is
// registered. A scroll adds ST_SCROLL and ST_FILL (one cell copied per cycle,
// then the bottom row filled); a clear adds ST_FILL (one cell written per cycle).
// Reset: the cursor homes and a clearing pass in ST_INIT writes white-on-black
// spaces into every cell; cmd_i stays not ready until it ends.
// A stalled response is held in its output register; the next command is
// still taken and waits in its final step until the register is free.
module text_mode_terminal_writer_core #(
  parameter int unsigned COLUMNS = tmtw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tmtw_pkg::ROWS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tmtw_cmd_if.sink   cmd_i,
  tmtw_rsp_if.source rsp_o,
  tmtw_cfg_if.sink   cfg_i
);
  import tmtw_pkg::*;

  localparam int unsigned CELLS  = COLUMNS * ROWS;
  localparam int unsigned ADDR_W = $clog2(CELLS);

  logic [BYTE_W-1:0] text_color_q;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= RESET_COLOR;
    end else if (cfg_i.valid) begin
      text_color_q <= cfg_i.text_color;
    end
  end

  tmtw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .ADDR_W  (ADDR_W)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .text_color_i (text_color_q),
    .cmd_i        (cmd_i),
    .rsp_o        (rsp_o),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  tmtw_screen_ram #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_screen_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
